>>> design/ipv6nt_pkg.sv
// ----------------------------------------------------------------------------
// IPv6 neighbor table package
// Shared sizes, entry layout, status codes and cell control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package ipv6nt_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam int KEY_W   = 64;
  localparam int MAC_W   = 48;
  localparam int STAT_W  = 3;

  localparam int IN_DATA_W  = 2 * KEY_W + MAC_W;                 // 176, whole bytes
  localparam int OUT_USED_W = STAT_W + MAC_W;                    // 51
  localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;        // 56

  localparam logic [7:0] MCAST_FIRST  = 8'hff;
  localparam logic [7:0] MCAST_PREFIX = 8'h33;

  localparam logic MODE_ADD    = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  localparam logic [STAT_W-1:0] STAT_UPDATED   = 3'd0;
  localparam logic [STAT_W-1:0] STAT_INSERTED  = 3'd1;
  localparam logic [STAT_W-1:0] STAT_REFUSED   = 3'd2;
  localparam logic [STAT_W-1:0] STAT_FOUND     = 3'd3;
  localparam logic [STAT_W-1:0] STAT_MAPPED    = 3'd4;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd5;
  localparam logic [STAT_W-1:0] STAT_INVALID   = 3'd6;

  typedef struct packed {
    logic [KEY_W-1:0] key_hi;
    logic [KEY_W-1:0] key_lo;
    logic [MAC_W-1:0] mac;
  } entry_t;

  typedef struct packed {
    logic shift;     // rotate the ring by one cell
    logic load_key;  // write key and MAC
    logic load_mac;  // write MAC only
  } cell_ctl_t;

endpackage

`default_nettype wire

>>> design/ipv6nt_cell.sv
// ----------------------------------------------------------------------------
// IPv6 neighbor table cell
// One table entry; rotates to its neighbor during a scan, loads on commit.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv6nt_cell
  import ipv6nt_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire cell_ctl_t ctl,
  input  wire entry_t    nb,
  input  wire entry_t    wr,
  output entry_t         ent
);

  always_ff @(posedge clk) begin
    if (rst) begin
      ent <= '0;
    end else if (ctl.shift) begin
      ent <= nb;
    end else if (ctl.load_key) begin
      ent <= wr;
    end else if (ctl.load_mac) begin
      ent.mac <= wr.mac;
    end
  end

endmodule

`default_nettype wire

>>> design/ipv6_neighbor_table.sv
// ----------------------------------------------------------------------------
// IPv6 neighbor table
// Fixed IPv6-to-MAC table with round-robin replacement, held in a ring of
// cells that rotates past one compare point during a lookup.
// ----------------------------------------------------------------------------
//  channel   dir  tdata (low bit up)                    tuser
//  s_axis    in   addr_high, addr_low, mac_in           mode
//  m_axis    out  status, mac_out, zero pad             -
//
//  A table lookup is accepted, then each entry is compared in turn as the
//  ring rotates past the compare point, then the result commits. Refused
//  adds, zero and multicast searches go from accept straight to commit.
//  Reset clears every entry and the victim pointer at once.
//  One item is in work at a time; a new beat is taken while a result waits,
//  and the commit cycle holds until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv6_neighbor_table
  import ipv6nt_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // addr_high, addr_low, mac_in
  input  wire logic                  s_axis_tuser,  // mode
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata   // status, mac_out, zero pad
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;

  localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

  state_t             state;
  logic               q_mode;
  logic [KEY_W-1:0]   q_hi;
  logic [KEY_W-1:0]   q_lo;
  logic [MAC_W-1:0]   q_mac;
  logic               q_direct;
  logic [STAT_W-1:0]  q_status;
  logic [MAC_W-1:0]   q_dmac;
  logic [IDX_W-1:0]   count;
  logic               found;
  logic [IDX_W-1:0]   hit_idx;
  logic [MAC_W-1:0]   hit_mac;
  logic [IDX_W-1:0]   victim;
  logic               out_valid;
  logic [STAT_W-1:0]  out_status;
  logic [MAC_W-1:0]   out_mac;

  entry_t             ents [ENTRIES];
  entry_t             wr;
  logic               in_hit;
  logic [KEY_W-1:0]   in_hi;
  logic [KEY_W-1:0]   in_lo;
  logic [MAC_W-1:0]   in_mac;
  logic               in_mcast;
  logic               in_zero;
  logic               hit;
  logic               out_free;
  logic               commit_upd;
  logic               commit_ins;
  logic [STAT_W-1:0]  status_sel;
  logic [MAC_W-1:0]   mac_sel;

  assign in_hi    = s_axis_tdata[KEY_W-1:0];
  assign in_lo    = s_axis_tdata[2*KEY_W-1:KEY_W];
  assign in_mac   = s_axis_tdata[IN_DATA_W-1:2*KEY_W];
  assign in_hit   = s_axis_tvalid && s_axis_tready;
  assign in_mcast = (in_hi[KEY_W-1 -: 8] == MCAST_FIRST);
  assign in_zero  = (in_hi == '0) && (in_lo == '0);

  assign hit      = (ents[0].key_hi == q_hi) && (ents[0].key_lo == q_lo);
  assign out_free = !out_valid || m_axis_tready;

  assign commit_upd = (state == S_DONE) && out_free && !q_direct &&
                      (q_mode == MODE_ADD) && found;
  assign commit_ins = (state == S_DONE) && out_free && !q_direct &&
                      (q_mode == MODE_ADD) && !found;

  assign wr = '{key_hi: q_hi, key_lo: q_lo, mac: q_mac};

  always_comb begin
    if (q_direct) begin
      status_sel = q_status;
      mac_sel    = q_dmac;
    end else if (q_mode == MODE_SEARCH) begin
      status_sel = found ? STAT_FOUND : STAT_NOT_FOUND;
      mac_sel    = found ? hit_mac : '0;
    end else begin
      status_sel = found ? STAT_UPDATED : STAT_INSERTED;
      mac_sel    = '0;
    end
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    cell_ctl_t ctl;
    assign ctl.shift    = (state == S_SCAN);
    assign ctl.load_key = commit_ins && (victim == IDX_W'(i));
    assign ctl.load_mac = commit_upd && (hit_idx == IDX_W'(i));

    ipv6nt_cell u_cell (
      .clk (clk),
      .rst (rst),
      .ctl (ctl),
      .nb  (ents[(i + 1) % ENTRIES]),
      .wr  (wr),
      .ent (ents[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      victim    <= '0;
      found     <= 1'b0;
      count     <= '0;
      q_direct  <= 1'b0;
    end else begin
      // in S_DONE a taken result is replaced by the new one below
      if (m_axis_tvalid && m_axis_tready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_hit) begin
            q_mode <= s_axis_tuser;
            q_hi   <= in_hi;
            q_lo   <= in_lo;
            q_mac  <= in_mac;
            q_dmac <= '0;
            found  <= 1'b0;
            count  <= '0;
            priority if (s_axis_tuser == MODE_ADD && (in_mcast || in_zero)) begin
              q_direct <= 1'b1;
              q_status <= STAT_REFUSED;
              state    <= S_DONE;
            end else if (s_axis_tuser == MODE_SEARCH && in_zero) begin
              q_direct <= 1'b1;
              q_status <= STAT_INVALID;
              state    <= S_DONE;
            end else if (s_axis_tuser == MODE_SEARCH && in_mcast) begin
              q_direct <= 1'b1;
              q_status <= STAT_MAPPED;
              q_dmac   <= {MCAST_PREFIX, MCAST_PREFIX, in_lo[31:0]};
              state    <= S_DONE;
            end else begin
              q_direct <= 1'b0;
              q_status <= STAT_NOT_FOUND;
              state    <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // lowest index wins: only the first hit is kept
          if (hit && !found) begin
            found   <= 1'b1;
            hit_idx <= count;
            hit_mac <= ents[0].mac;
          end
          count <= count + 1'b1;
          if (count == LAST) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_status <= status_sel;
            out_mac    <= mac_sel;
            state      <= S_IDLE;
            if (commit_ins) begin
              victim <= (victim == LAST) ? '0 : victim + 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {(OUT_DATA_W - OUT_USED_W)'(0), out_mac, out_status};

  a_scan_blocks_input: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> !s_axis_tready)
    else $error("input taken during scan");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> state != S_IDLE)
    else $error("accepted beat not started");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state) == S_DONE)
    else $error("result raised outside commit");

  a_victim_range: assert property (@(posedge clk) disable iff (rst)
    victim <= LAST)
    else $error("victim pointer out of range");

  a_single_commit: assert property (@(posedge clk) disable iff (rst)
    !(commit_ins && commit_upd))
    else $error("insert and update in one commit");

endmodule

`default_nettype wire
